// ----- sv/cbht_pkg.sv -----
// cbht_pkg: types and constants of the chained bucket hash table
// no dependencies
`timescale 1ns / 1ps
package cbht_pkg;
  localparam int unsigned BucketsDef  = 256;
  localparam int unsigned CellsDef    = 4;
  localparam int unsigned SparesDef   = 256;
  localparam int unsigned KeyBitsDef  = 32;
  localparam int unsigned HandleBitsDef = 16;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeLookup = 1'b1;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusDrop = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [KeyBitsDef-1:0]    key;
    logic [HandleBitsDef-1:0] entry_handle;
  } cbht_in_t;

  typedef struct packed {
    logic                     found;
    logic [HandleBitsDef-1:0] found_handle;
    logic                     status;
  } cbht_out_t;
endpackage

// ----- sv/chained_bucket_hash_table.sv -----
// chained_bucket_hash_table: top level, sequencer over the bucket memories
// depends on cbht_pkg and cbht_ram
`timescale 1ns / 1ps
//  channel | dir | handshake             | payload
//  in      | in  | in_valid_i/in_ready_o | cbht_in_t  (mode, key, entry_handle)
//  out     | out | out_valid_o/out_ready_i | cbht_out_t (found, found_handle, status)
//
//  one item at a time; each memory has one read port with a registered read
//  insert: into the head while it has room, else into the first overflow bucket,
//  read first, while that has room, else into a fresh bucket spliced in behind the head
//  lookup: scans the head cells, then the overflow buckets along the links; stops on a hit
//  after reset a clearing pass sets every head to empty/no link
//  the next item is taken only once the finished beat leaves, or in the cycle it leaves
module chained_bucket_hash_table
  import cbht_pkg::*;
#(
  parameter int unsigned Buckets    = BucketsDef,
  parameter int unsigned Cells      = CellsDef,
  parameter int unsigned Spares     = SparesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cbht_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cbht_out_t out_data_o
);
  localparam int unsigned KeyBits    = KeyBitsDef;
  localparam int unsigned HandleBits = HandleBitsDef;
  localparam int unsigned BW  = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned SW  = (Spares > 1) ? $clog2(Spares) : 1;
  localparam int unsigned CW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned FW  = $clog2(Cells + 1);
  localparam int unsigned LW  = $clog2(Spares + 1);
  // bucket descriptor: fill count and link (Spares means no link)
  localparam int unsigned DW  = FW + LW;
  // one cell memory holds heads first, then spares
  localparam int unsigned NB  = Buckets + Spares;
  localparam int unsigned NBW = $clog2(NB);
  localparam int unsigned CEW = KeyBits + HandleBits;
  localparam int unsigned NC  = NB * Cells;
  localparam int unsigned NCW = $clog2(NC);
  localparam logic [LW-1:0] NoLink = LW'(Spares);

  typedef enum logic [3:0] {
    StClear, StIdle, StRdHead, StWtHead, StDecide, StRdSpare, StWtSpare,
    StInsSpare, StScanRd, StScanCmp, StNext, StWtNext, StDone
  } state_e;

  state_e state_q;
  logic [NBW-1:0] clr_q;
  logic           mode_q;
  logic [KeyBits-1:0] key_q;
  logic [HandleBits-1:0] hdl_q;
  logic [BW-1:0]  bidx_q;
  logic [NBW-1:0] cur_q;    // bucket being scanned (combined index)
  logic [FW-1:0]  cfill_q;
  logic [LW-1:0]  clink_q;
  logic [FW-1:0]  hfill_q;
  logic [LW-1:0]  hlink_q;
  logic [CW-1:0]  cell_q;
  logic [LW-1:0]  used_q;
  logic [LW:0]    steps_q;
  cbht_out_t      res_q;
  logic           ovalid_q;

  // descriptor memory
  logic           d_we;
  logic [NBW-1:0] d_wa, d_ra;
  logic [DW-1:0]  d_wd, d_rd;
  // cell memory
  logic           c_we;
  logic [NCW-1:0] c_wa, c_ra;
  logic [CEW-1:0] c_wd, c_rd;

  cbht_ram #(.Width(DW), .Depth(NB)) u_desc (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(d_ra), .rdata_o(d_rd)
  );
  cbht_ram #(.Width(CEW), .Depth(NC)) u_cells (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .raddr_i(c_ra), .rdata_o(c_rd)
  );

  logic [FW-1:0] rd_fill;
  logic [LW-1:0] rd_link;
  assign rd_fill = d_rd[DW-1:LW];
  assign rd_link = d_rd[LW-1:0];

  function automatic logic [NCW-1:0] cell_addr(logic [NBW-1:0] b, logic [CW-1:0] c);
    cell_addr = NCW'(b) * NCW'(Cells) + NCW'(c);
  endfunction

  logic [NBW-1:0] spare_base;
  assign spare_base = NBW'(Buckets);

  // in-flight item may be accepted only when idle and the output slot frees
  assign in_ready_o  = (state_q == StIdle) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

  logic key_hit;
  assign key_hit = c_rd[CEW-1:HandleBits] == key_q;

  // head link update after splicing a fresh spare is a separate write, made in StDone
  logic head_relink_q;

  // memory port control, combinational from state
  always_comb begin
    d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = {key_q, hdl_q}; c_ra = '0;
    case (state_q)
      StClear: begin
        d_we = 1'b1; d_wa = clr_q; d_wd = {FW'(0), NoLink};
      end
      StIdle: d_ra = NBW'(in_data_i.key[BW-1:0] & BW'(Buckets - 1));
      // address held through the wait so the read data stays put
      StRdSpare, StWtSpare: d_ra = spare_base + NBW'(hlink_q[SW-1:0]);
      StDecide: begin
        if (mode_q == ModeInsert && hfill_q < FW'(Cells)) begin
          d_we = 1'b1; d_wa = NBW'(bidx_q); d_wd = {hfill_q + FW'(1), hlink_q};
          c_we = 1'b1; c_wa = cell_addr(NBW'(bidx_q), hfill_q[CW-1:0]);
        end
      end
      StInsSpare: begin
        if (hlink_q != NoLink && rd_fill < FW'(Cells)) begin
          d_we = 1'b1; d_wa = spare_base + NBW'(hlink_q[SW-1:0]);
          d_wd = {rd_fill + FW'(1), rd_link};
          c_we = 1'b1;
          c_wa = cell_addr(spare_base + NBW'(hlink_q[SW-1:0]), rd_fill[CW-1:0]);
        end else if (used_q < LW'(Spares)) begin
          d_we = 1'b1; d_wa = spare_base + NBW'(used_q[SW-1:0]);
          d_wd = {FW'(1), hlink_q};
          c_we = 1'b1; c_wa = cell_addr(spare_base + NBW'(used_q[SW-1:0]), '0);
        end
      end
      StScanRd: c_ra = cell_addr(cur_q, cell_q);
      StNext: d_ra = spare_base + NBW'(clink_q[SW-1:0]);
      // head relink write: the descriptor port is free here
      StDone: begin
        if (head_relink_q) begin
          d_we = 1'b1; d_wa = NBW'(bidx_q); d_wd = {hfill_q, clink_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; used_q <= '0; ovalid_q <= 1'b0;
      head_relink_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StClear: begin
          if (clr_q == NBW'(Buckets - 1)) state_q <= StIdle;
          clr_q <= clr_q + NBW'(1);
        end
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            mode_q <= in_data_i.mode;
            key_q  <= in_data_i.key[KeyBits-1:0];
            hdl_q  <= in_data_i.entry_handle[HandleBits-1:0];
            bidx_q <= in_data_i.key[BW-1:0] & BW'(Buckets - 1);
            res_q  <= '0;
            state_q <= StWtHead;
          end
        end
        StWtHead: begin
          hfill_q <= rd_fill; hlink_q <= rd_link;
          state_q <= StDecide;
        end
        StDecide: begin
          cur_q <= NBW'(bidx_q); cfill_q <= hfill_q; clink_q <= hlink_q;
          cell_q <= '0; steps_q <= '0;
          if (mode_q == ModeInsert) begin
            state_q <= (hfill_q < FW'(Cells)) ? StDone
                     : (hlink_q != NoLink) ? StRdSpare : StInsSpare;
          end else begin
            state_q <= (hfill_q == '0) ? StNext : StScanRd;
          end
        end
        StRdSpare: state_q <= StWtSpare;
        StWtSpare: state_q <= StInsSpare;
        StInsSpare: begin
          // rd_fill valid only when a link exists (read in StRdSpare)
          if (hlink_q != NoLink && rd_fill < FW'(Cells)) begin
            state_q <= StDone;
          end else if (used_q < LW'(Spares)) begin
            used_q <= used_q + LW'(1);
            clink_q <= used_q; // new head link
            head_relink_q <= 1'b1;
            state_q <= StDone;
          end else begin
            res_q.status <= StatusDrop;
            state_q <= StDone;
          end
        end
        StScanRd: state_q <= StScanCmp;
        StScanCmp: begin
          if (key_hit) begin
            res_q.found <= 1'b1;
            res_q.found_handle <= c_rd[HandleBits-1:0];
            state_q <= StDone;
          end else if (FW'(cell_q) + FW'(1) < cfill_q) begin
            cell_q <= cell_q + CW'(1);
            state_q <= StScanRd;
          end else begin
            state_q <= StNext;
          end
        end
        StNext: begin
          if (clink_q == NoLink || steps_q >= (LW+1)'(Spares)) begin
            state_q <= StDone;
          end else begin
            cur_q <= spare_base + NBW'(clink_q[SW-1:0]);
            steps_q <= steps_q + (LW+1)'(1);
            state_q <= StWtNext;
          end
        end
        StWtNext: begin
          cfill_q <= rd_fill; clink_q <= rd_link; cell_q <= '0;
          state_q <= (rd_fill == '0) ? StNext : StScanRd;
        end
        StDone: begin
          ovalid_q <= 1'b1;
          head_relink_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- sv/cbht_ram.sv -----
// cbht_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module cbht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/cbht_checker.sv -----
// cbht_checker: port-level checks of the hash table, bound to the top level
// depends on cbht_pkg
`timescale 1ns / 1ps
module cbht_checker
  import cbht_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input cbht_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input cbht_out_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");
  a_lookup_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.status))
    else $error("found and drop flagged together");
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.found_handle == '0)
    else $error("handle without hit");
endmodule

bind chained_bucket_hash_table cbht_checker u_cbht_checker (.*);

// ----- dv/tb_chained_bucket_hash_table.sv -----
// tb_chained_bucket_hash_table: self-checking bench for the chained bucket hash table
// depends on cbht_pkg and the chained_bucket_hash_table rtl
`timescale 1ns / 1ps
module tb_chained_bucket_hash_table;
  import cbht_pkg::*;

  localparam int unsigned NumBuckets = BucketsDef;
  localparam int unsigned NumCells   = CellsDef;
  localparam int unsigned NumSpares  = SparesDef;
  localparam int unsigned NoLink     = NumSpares;

  // shadow table plus the queue of pending expected beats
  class table_scoreboard;
    logic [31:0] head_key    [NumBuckets*NumCells];
    logic [15:0] head_handle [NumBuckets*NumCells];
    int unsigned head_count  [NumBuckets];
    int unsigned head_next   [NumBuckets];
    logic [31:0] spare_key   [NumSpares*NumCells];
    logic [15:0] spare_handle[NumSpares*NumCells];
    int unsigned spare_count [NumSpares];
    int unsigned spare_next  [NumSpares];
    int unsigned spares_taken;
    cbht_out_t   expected_q[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < NumBuckets; i++) begin
        head_count[i] = 0;
        head_next[i]  = NoLink;
      end
      spares_taken = 0;
      mismatches   = 0;
    endfunction

    function logic insert_pair(int unsigned b, logic [31:0] k, logic [15:0] h);
      int unsigned nx;
      int unsigned s;
      nx = head_next[b];
      if (head_count[b] < NumCells) begin
        head_key[b*NumCells + head_count[b]]    = k;
        head_handle[b*NumCells + head_count[b]] = h;
        head_count[b]++;
        return StatusOk;
      end
      if (nx < NumSpares && spare_count[nx] < NumCells) begin
        spare_key[nx*NumCells + spare_count[nx]]    = k;
        spare_handle[nx*NumCells + spare_count[nx]] = h;
        spare_count[nx]++;
        return StatusOk;
      end
      if (spares_taken >= NumSpares) return StatusDrop;
      // fresh bucket goes right behind the head
      s = spares_taken;
      spares_taken++;
      spare_next[s]            = nx;
      spare_count[s]           = 1;
      spare_key[s*NumCells]    = k;
      spare_handle[s*NumCells] = h;
      head_next[b]             = s;
      return StatusOk;
    endfunction

    function void note(cbht_in_t beat);
      cbht_out_t   res;
      int unsigned b;
      int unsigned s;
      bit          hit;
      res = '0;
      hit = 0;
      b   = beat.key & (NumBuckets - 1);
      if (beat.mode == ModeInsert) begin
        res.status = insert_pair(b, beat.key, beat.entry_handle);
      end else begin
        for (int i = 0; i < head_count[b] && !hit; i++) begin
          if (head_key[b*NumCells + i] == beat.key) begin
            hit = 1;
            res.found_handle = head_handle[b*NumCells + i];
          end
        end
        s = head_next[b];
        for (int n = 0; n < NumSpares && s < NumSpares && !hit; n++) begin
          for (int i = 0; i < spare_count[s] && !hit; i++) begin
            if (spare_key[s*NumCells + i] == beat.key) begin
              hit = 1;
              res.found_handle = spare_handle[s*NumCells + i];
            end
          end
          s = spare_next[s];
        end
        res.found = hit;
      end
      expected_q.push_back(res);
    endfunction

    function void check(cbht_out_t got);
      cbht_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found || got.found_handle !== want.found_handle ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected found=%0d handle=%h status=%0d, ",
                    "got found=%0d handle=%h status=%0d"},
                   want.found, want.found_handle, want.status,
                   got.found, got.found_handle, got.status);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  cbht_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  cbht_out_t out_data_o;

  table_scoreboard sb;
  bit          quiet;          // no idling on either side
  int          hold_left;      // receiver stall cycles still to go
  logic [31:0] keys_seen[$];   // inserted keys, reused for hits and duplicates
  logic [7:0]  hot_bucket[4];  // few buckets that take deep chains

  chained_bucket_hash_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(input cbht_in_t beat);
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(beat);
    if (beat.mode == ModeInsert && keys_seen.size() < 2000) keys_seen.push_back(beat.key);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic send_op(input logic m, input logic [31:0] k, input logic [15:0] h);
    cbht_in_t beat;
    beat.mode         = m;
    beat.key          = k;
    beat.entry_handle = h;
    send_beat(beat);
  endtask

  // sender pause until every expected beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key(input int hit_pct);
    if (keys_seen.size() > 0 && $urandom_range(0, 99) < hit_pct)
      return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
    return {24'($urandom() >> 8), hot_bucket[$urandom_range(0, 3)]};
  endfunction

  // receiver: random stall bursts, long hold when requested
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 18) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check(out_data_o);
    end
  end

  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb         = new();
    quiet      = 0;
    hold_left  = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    for (int i = 0; i < 4; i++) hot_bucket[i] = 8'($urandom_range(0, 255));
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, miss in an empty and a populated bucket, duplicates
    send_op(ModeLookup, 32'h0000_0000, 16'hffff);
    send_op(ModeInsert, 32'h0000_0000, 16'h0000);
    send_op(ModeInsert, 32'hffff_ffff, 16'hffff);
    send_op(ModeLookup, 32'hffff_ffff, 16'h0000);
    send_op(ModeLookup, 32'h0000_0000, 16'h0000);
    send_op(ModeLookup, 32'h0000_0100, 16'h0000);
    send_op(ModeInsert, 32'h0000_0000, 16'h1234);
    send_op(ModeLookup, 32'h0000_0000, 16'h5555);
    // fill bucket 0x5a past the head so a chain forms
    for (int i = 0; i < 10; i++) send_op(ModeInsert, {24'(i), 8'h5a}, 16'(16'ha000 + i));
    send_op(ModeLookup, {24'd9, 8'h5a}, 16'h0000);
    send_op(ModeLookup, {24'd5, 8'h5a}, 16'h0000);
    send_op(ModeLookup, {24'd2, 8'h5a}, 16'h0000);
    send_op(ModeLookup, {24'd77, 8'h5a}, 16'h0000);
    drain();

    // random, insert heavy on hot buckets so long chains build up
    for (int i = 0; i < 670; i++) begin
      if ($urandom_range(0, 99) < 85)
        send_op(ModeInsert, pick_key(20), 16'($urandom()));
      else
        send_op(ModeLookup, pick_key(60), 16'($urandom()));
    end

    // receiver holds off while the sender keeps offering, input stalls
    hold_left = 400;
    for (int i = 0; i < 60; i++)
      send_op(1'($urandom_range(0, 1)), pick_key(50), 16'($urandom()));
    drain();

    // mostly lookups across the whole key space, quiet at the end
    for (int i = 0; i < 200; i++) begin
      if (i == 150) quiet = 1;
      if ($urandom_range(0, 2) == 0)
        send_op(ModeLookup, $urandom(), 16'($urandom()));
      else
        send_op($urandom_range(0, 4) == 0 ? ModeInsert : ModeLookup, pick_key(70),
                16'($urandom()));
    end
    drain();
    repeat (50) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- chained_bucket_hash_table.f -----
sv/cbht_pkg.sv
sv/cbht_ram.sv
sv/chained_bucket_hash_table.sv
sv/cbht_checker.sv
dv/tb_chained_bucket_hash_table.sv
